// ===== src/mkhm_pkg.sv =====
// Shared types and constants for the multi-key hash map unit.
package mkhm_pkg;

    localparam int TSIZE_W = 11;
    localparam int COUNT_W = 13;
    localparam int HASH_W  = 64;
    localparam int FUNC_W  = 2;
    localparam int ARITY_W = 2;
    localparam int CIDX_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_KEY_ARITY  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TABLE_SIZE = 2'd1;

    localparam logic [HASH_W-1:0] SEED_ONE   = 64'd137;
    localparam logic [HASH_W-1:0] SEED_TWO   = 64'd317;
    localparam logic [HASH_W-1:0] SEED_THREE = 64'd731;

    // hash bits folded into the remainder per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = HASH_W / MOD_BITS;
    localparam int STEP_W    = 4;
    // times-31 is a shift by 5 and a subtract
    localparam int MUL_SHIFT = 5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_SCAN,
        ST_CHK,
        ST_ACT,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

endpackage

// ===== src/multi_key_hash_map_unit.sv =====
// Multi-key hash map unit: hash sequencer, bucket count memory and slot memory.
// Sequence: seed plus first key, a times-31 step per key, hash mod table size, bucket count read,
// slot compares until a hit, then a put write or pop slot shift (hash mod table size folds 4 bits a cycle).
// Throughput: one item at a time; the next is taken once the result sits in the output register.
// Reset: arity 1, table size 1024, total zero; then a clear pass zeroes every bucket fill
// count, during which no item is accepted.
module multi_key_hash_map_unit #(
    parameter int MAX_BUCKETS  = 1024,
    parameter int BUCKET_DEPTH = 4,
    parameter int KEY_WIDTH    = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mkhm_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [mkhm_pkg::TSIZE_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mkhm_pkg::FUNC_W-1:0]    func,
    input  logic [KEY_WIDTH-1:0]           key_first,
    input  logic [KEY_WIDTH-1:0]           key_second,
    input  logic [KEY_WIDTH-1:0]           key_third,
    input  logic [VALUE_WIDTH-1:0]         new_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [VALUE_WIDTH-1:0]         old_value,
    output logic                           bucket_full,
    output logic [mkhm_pkg::COUNT_W-1:0]   stored_count
);

    localparam int SLOTS = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int SZ_W  = $clog2(MAX_BUCKETS + 1);
    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(BUCKET_DEPTH + 1);
    localparam int EW    = 3 * KEY_WIDTH + VALUE_WIDTH;
    localparam int K1_LO = 2 * KEY_WIDTH + VALUE_WIDTH;
    localparam int K2_LO = KEY_WIDTH + VALUE_WIDTH;
    localparam int K3_LO = VALUE_WIDTH;

    mkhm_pkg::state_t state_reg, state_next;

    logic [mkhm_pkg::ARITY_W-1:0] arity_reg;
    logic [mkhm_pkg::TSIZE_W-1:0] size_reg;
    logic [mkhm_pkg::FUNC_W-1:0]  op_reg;
    logic [KEY_WIDTH-1:0]         k1_reg, k2_reg, k3_reg;
    logic [VALUE_WIDTH-1:0]       val_reg;
    logic [mkhm_pkg::ARITY_W-1:0] ar_reg;
    logic [mkhm_pkg::HASH_W-1:0]  h_reg;
    logic [mkhm_pkg::STEP_W-1:0]  step_reg;
    logic [SZ_W-1:0]              rem_reg;
    logic [SW-1:0]                base_reg;
    logic [CW-1:0]                used_reg, idx_reg, hit_reg;
    logic                         have_reg, full_reg;
    logic [VALUE_WIDTH-1:0]       old_reg;
    logic [mkhm_pkg::COUNT_W-1:0] total_reg;
    logic [BW-1:0]                clr_reg;
    logic                         out_valid_reg, found_out_reg, full_out_reg;
    logic [VALUE_WIDTH-1:0]       old_out_reg;
    logic [mkhm_pkg::COUNT_W-1:0] count_out_reg;

    // memories
    logic [EW-1:0] slot_mem [SLOTS];
    logic [CW-1:0] cnt_mem  [MAX_BUCKETS];
    logic [EW-1:0] slot_q;
    logic [CW-1:0] cnt_q;

    logic          slot_we, slot_re, cnt_we, cnt_re;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [EW-1:0] slot_wdata;
    logic [BW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;

    logic [mkhm_pkg::ARITY_W-1:0] ar_eff;
    logic [SZ_W-1:0]              size_eff;
    logic [31:0]                  size32;
    logic [mkhm_pkg::HASH_W-1:0]  seed;
    logic [mkhm_pkg::HASH_W-1:0]  mul_in, mul_out;
    logic [SZ_W-1:0]              rem_fold;
    logic                         key_hit, accept_in, out_load, last_mul;
    logic [CW-1:0]                idx_inc;
    logic [BW-1:0]                bucket;

    assign cfg_ready    = 1'b1;
    assign in_stall     = (state_reg != mkhm_pkg::ST_IDLE);
    assign accept_in    = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign found        = found_out_reg;
    assign old_value    = old_out_reg;
    assign bucket_full  = full_out_reg;
    assign stored_count = count_out_reg;
    assign idx_inc      = idx_reg + CW'(1);
    assign bucket       = rem_reg[BW-1:0];
    assign last_mul     = (step_reg == mkhm_pkg::STEP_W'(ar_reg - 2'd1));
    assign out_load     = (state_reg == mkhm_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // arity 0 acts as 1; size 0 acts as 1 and is capped at MAX_BUCKETS
    always_comb
    begin
        ar_eff = (arity_reg == 2'd0) ? 2'd1 : arity_reg;
        if (size_reg == '0)
            size32 = 32'd1;
        else if (32'(size_reg) > 32'(MAX_BUCKETS))
            size32 = 32'(MAX_BUCKETS);
        else
            size32 = 32'(size_reg);
        size_eff = size32[SZ_W-1:0];
        case (ar_eff)
            2'd2:    seed = mkhm_pkg::SEED_TWO;
            2'd3:    seed = mkhm_pkg::SEED_THREE;
            default: seed = mkhm_pkg::SEED_ONE;
        endcase
    end

    // xor in the second or third key on later steps, then times 31
    always_comb
    begin
        case (step_reg)
            4'd1:    mul_in = h_reg ^ mkhm_pkg::HASH_W'(k2_reg);
            4'd2:    mul_in = h_reg ^ mkhm_pkg::HASH_W'(k3_reg);
            default: mul_in = h_reg;
        endcase
        mul_out = (mul_in << mkhm_pkg::MUL_SHIFT) - mul_in;
    end

    // restoring remainder, MSB first, a few bits per cycle
    always_comb
    begin
        logic [SZ_W:0] r;
        r = {1'b0, rem_reg};
        for (int j = 0; j < mkhm_pkg::MOD_BITS; j++)
        begin
            r = {r[SZ_W-1:0], h_reg[mkhm_pkg::HASH_W-1-j]};
            if (r >= {1'b0, size_eff})
                r = r - {1'b0, size_eff};
        end
        rem_fold = r[SZ_W-1:0];
    end

    assign key_hit = (slot_q[K1_LO +: KEY_WIDTH] == k1_reg)
                  && (ar_reg < 2'd2 || slot_q[K2_LO +: KEY_WIDTH] == k2_reg)
                  && (ar_reg < 2'd3 || slot_q[K3_LO +: KEY_WIDTH] == k3_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mkhm_pkg::ST_CLEAR:
                if (clr_reg == BW'(MAX_BUCKETS - 1))
                    state_next = mkhm_pkg::ST_IDLE;
            mkhm_pkg::ST_IDLE:
                if (accept_in)
                    state_next = mkhm_pkg::ST_MUL;
            mkhm_pkg::ST_MUL:
                if (last_mul)
                    state_next = mkhm_pkg::ST_MOD;
            mkhm_pkg::ST_MOD:
                if (step_reg == mkhm_pkg::STEP_W'(mkhm_pkg::MOD_STEPS - 1))
                    state_next = mkhm_pkg::ST_CNT_RD;
            mkhm_pkg::ST_CNT_RD:
                state_next = mkhm_pkg::ST_CNT_WAIT;
            mkhm_pkg::ST_CNT_WAIT:
                state_next = mkhm_pkg::ST_SCAN;
            mkhm_pkg::ST_SCAN:
                state_next = (idx_reg == used_reg) ? mkhm_pkg::ST_ACT : mkhm_pkg::ST_CHK;
            mkhm_pkg::ST_CHK:
                state_next = key_hit ? mkhm_pkg::ST_ACT : mkhm_pkg::ST_SCAN;
            mkhm_pkg::ST_ACT:
                if (op_reg == mkhm_pkg::FUNC_POP && have_reg)
                    state_next = mkhm_pkg::ST_SHIFT;
                else
                    state_next = mkhm_pkg::ST_DONE;
            mkhm_pkg::ST_SHIFT:
                state_next = (idx_inc < used_reg) ? mkhm_pkg::ST_SHIFT_WR : mkhm_pkg::ST_DONE;
            mkhm_pkg::ST_SHIFT_WR:
                state_next = mkhm_pkg::ST_SHIFT;
            mkhm_pkg::ST_DONE:
                if (out_load)
                    state_next = mkhm_pkg::ST_IDLE;
            default:
                state_next = mkhm_pkg::ST_IDLE;
        endcase
    end

    // memory strobes
    always_comb
    begin
        slot_we    = 1'b0;
        slot_re    = 1'b0;
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        slot_waddr = base_reg + SW'(idx_reg);
        slot_raddr = base_reg + SW'(idx_reg);
        slot_wdata = {k1_reg, k2_reg, k3_reg, val_reg};
        cnt_waddr  = bucket;
        cnt_wdata  = used_reg;
        unique case (state_reg)
            mkhm_pkg::ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
            end
            mkhm_pkg::ST_CNT_RD:
                cnt_re = 1'b1;
            mkhm_pkg::ST_SCAN:
                slot_re = (idx_reg != used_reg);
            mkhm_pkg::ST_ACT:
                if (op_reg == mkhm_pkg::FUNC_PUT)
                begin
                    if (have_reg)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = base_reg + SW'(hit_reg);
                        slot_wdata = {slot_q[EW-1:VALUE_WIDTH], val_reg};
                    end
                    else if (used_reg < CW'(BUCKET_DEPTH))
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = base_reg + SW'(used_reg);
                        cnt_we     = 1'b1;
                        cnt_wdata  = used_reg + CW'(1);
                    end
                end
            mkhm_pkg::ST_SHIFT:
                if (idx_inc < used_reg)
                begin
                    slot_re    = 1'b1;
                    slot_raddr = base_reg + SW'(idx_inc);
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = used_reg - CW'(1);
                end
            mkhm_pkg::ST_SHIFT_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_q;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (slot_re)
            slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_q <= cnt_mem[bucket];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mkhm_pkg::ST_CLEAR;
            arity_reg     <= 2'd1;
            size_reg      <= mkhm_pkg::TSIZE_W'(1024);
            total_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mkhm_pkg::CFG_KEY_ARITY:  arity_reg <= cfg_data[mkhm_pkg::ARITY_W-1:0];
                    mkhm_pkg::CFG_TABLE_SIZE: size_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                mkhm_pkg::ST_CLEAR:
                    clr_reg <= clr_reg + BW'(1);
                mkhm_pkg::ST_IDLE:
                    if (accept_in)
                    begin
                        op_reg   <= func;
                        k1_reg   <= key_first;
                        k2_reg   <= key_second;
                        k3_reg   <= key_third;
                        val_reg  <= new_value;
                        ar_reg   <= ar_eff;
                        h_reg    <= seed + mkhm_pkg::HASH_W'(key_first);
                        step_reg <= '0;
                        have_reg <= 1'b0;
                        full_reg <= 1'b0;
                        old_reg  <= '0;
                    end
                mkhm_pkg::ST_MUL:
                begin
                    h_reg    <= mul_out;
                    step_reg <= last_mul ? '0 : step_reg + mkhm_pkg::STEP_W'(1);
                    rem_reg  <= '0;
                end
                mkhm_pkg::ST_MOD:
                begin
                    rem_reg  <= rem_fold;
                    h_reg    <= h_reg << mkhm_pkg::MOD_BITS;
                    step_reg <= step_reg + mkhm_pkg::STEP_W'(1);
                end
                mkhm_pkg::ST_CNT_RD:
                    base_reg <= SW'(bucket) * SW'(BUCKET_DEPTH);
                mkhm_pkg::ST_CNT_WAIT:
                begin
                    used_reg <= cnt_q;
                    idx_reg  <= '0;
                end
                mkhm_pkg::ST_CHK:
                    if (key_hit)
                    begin
                        have_reg <= 1'b1;
                        hit_reg  <= idx_reg;
                        old_reg  <= slot_q[VALUE_WIDTH-1:0];
                    end
                    else
                        idx_reg <= idx_inc;
                mkhm_pkg::ST_ACT:
                    if (op_reg == mkhm_pkg::FUNC_PUT && !have_reg)
                    begin
                        if (used_reg < CW'(BUCKET_DEPTH))
                            total_reg <= total_reg + mkhm_pkg::COUNT_W'(1);
                        else
                            full_reg <= 1'b1;
                    end
                    else if (op_reg == mkhm_pkg::FUNC_POP && have_reg)
                        idx_reg <= hit_reg;
                mkhm_pkg::ST_SHIFT:
                    if (!(idx_inc < used_reg))
                        total_reg <= total_reg - mkhm_pkg::COUNT_W'(1);
                mkhm_pkg::ST_SHIFT_WR:
                    idx_reg <= idx_inc;
                mkhm_pkg::ST_DONE:
                    if (out_load)
                    begin
                        found_out_reg <= have_reg;
                        old_out_reg   <= old_reg;
                        full_out_reg  <= full_reg;
                        count_out_reg <= total_reg;
                    end
                default:
                begin
                end
            endcase
        end
    end

endmodule
